### rtl/lspg_pkg.sv
// lspg_pkg: shared types, stage numbers and constants of the strip pair geometry pipeline
`default_nettype none
package lspg_pkg;

    // pipeline depth and the stage at which each piece of work happens
    localparam int DEPTH   = 45;
    localparam int S_SQR   = 1;   // squares of the differences, cordic start vector
    localparam int S_RAD   = 2;   // radicand, length ratio divider set-up
    localparam int S_IT0   = 3;   // first iteration of root, cordic and length divider
    localparam int N_ROOT  = 25;  // root bits
    localparam int N_CORD  = 16;  // cordic iterations
    localparam int N_QUO   = 16;  // quotient bits of each divider
    localparam int S_ERR   = 19;  // absolute angle deviations
    localparam int S_ERQ   = 20;  // rounding and saturation of the deviation
    localparam int S_WRI   = 28;  // width ratio divider set-up

    localparam logic signed [20:0] ANG_PI      = 21'sd205887;
    localparam logic signed [21:0] ANG_HALF_PI = 22'sd102944;
    localparam logic [14:0]        ERR_MAX     = 15'h7FFF;

    // one request as it arrives
    typedef struct packed {
        logic [15:0] lx;
        logic [15:0] ly;
        logic [15:0] ll;
        logic [14:0] la;
        logic [15:0] rx;
        logic [15:0] ry;
        logic [15:0] rl;
        logic [14:0] ra;
    } t_req;

    // working state carried down the pipeline
    typedef struct packed {
        logic [15:0]        mid_x;
        logic [15:0]        mid_y;
        logic [15:0]        maxl;
        logic [15:0]        minl;
        logic [14:0]        la;
        logic [14:0]        ra;
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic [32:0]        sqx;
        logic [32:0]        sqy;
        logic [49:0]        rad;
        logic [24:0]        root;
        logic [27:0]        srem;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [20:0] cz;
        logic               zr;
        logic [20:0]        ea;
        logic [20:0]        eb;
        logic [14:0]        err;
        logic [15:0]        lrem;
        logic [15:0]        llo;
        logic [15:0]        lq;
        logic               lsat;
        logic [15:0]        wrem;
        logic [15:0]        wlo;
        logic [15:0]        wq;
        logic               wsat;
    } t_item;

    // atan(2^-i) in units of 2^-16 rad
    function automatic logic signed [20:0] f_atan(input int i);
        logic signed [20:0] v;
        case (i)
            0:       v = 21'sd51472;
            1:       v = 21'sd30385;
            2:       v = 21'sd16055;
            3:       v = 21'sd8150;
            4:       v = 21'sd4091;
            5:       v = 21'sd2047;
            6:       v = 21'sd1024;
            7:       v = 21'sd512;
            8:       v = 21'sd256;
            9:       v = 21'sd128;
            10:      v = 21'sd64;
            11:      v = 21'sd32;
            12:      v = 21'sd16;
            13:      v = 21'sd8;
            14:      v = 21'sd4;
            15:      v = 21'sd2;
            default: v = 21'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### rtl/lspg_pipe.sv
// lspg_pipe: the geometry datapath, one iteration of each unit per register stage
`default_nettype none
module lspg_pipe (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_vld,
    input  wire lspg_pkg::t_req i_req,
    output logic                o_vld,
    output lspg_pkg::t_item     o_item
);
    import lspg_pkg::*;

    logic [DEPTH-1:0] r_vld;
    t_item            r_st [DEPTH];
    t_item            n_st [DEPTH];

    // first stage: differences, midpoints, longer and shorter length
    function automatic t_item f_load(input t_req q);
        t_item       r;
        logic [16:0] sx;
        logic [16:0] sy;
        r       = '0;
        sx      = {1'b0, q.lx} + {1'b0, q.rx};
        sy      = {1'b0, q.ly} + {1'b0, q.ry};
        r.mid_x = sx[16:1];
        r.mid_y = sy[16:1];
        r.dx    = $signed({1'b0, q.rx}) - $signed({1'b0, q.lx});
        r.dy    = $signed({1'b0, q.ry}) - $signed({1'b0, q.ly});
        r.maxl  = (q.ll > q.rl) ? q.ll : q.rl;
        r.minl  = (q.ll > q.rl) ? q.rl : q.ll;
        r.la    = q.la;
        r.ra    = q.ra;
        return r;
    endfunction

    // work done between stage k-1 and stage k
    function automatic t_item f_step(input t_item s, input int k);
        t_item              r;
        logic signed [33:0] px;
        logic signed [33:0] py;
        logic [33:0]        sm;
        logic [27:0]        sr;
        logic [27:0]        tr;
        logic [16:0]        dr;
        logic signed [31:0] xs;
        logic signed [31:0] ys;
        logic signed [20:0] roll;
        logic signed [21:0] ea;
        logic signed [21:0] eb;
        logic [20:0]        em;
        logic [21:0]        rs;
        r = s;
        // squares and cordic start vector, left half plane folded over
        if (k == S_SQR) begin
            px    = s.dx * s.dx;
            py    = s.dy * s.dy;
            r.sqx = px[32:0];
            r.sqy = py[32:0];
            xs    = {{3{s.dx[16]}}, s.dx, 12'b0};
            ys    = {{3{s.dy[16]}}, s.dy, 12'b0};
            r.zr  = (s.dx == 17'sd0) && (s.dy == 17'sd0);
            if (s.dx[16]) begin
                r.cx = -xs;
                r.cy = -ys;
                r.cz = s.dy[16] ? -ANG_PI : ANG_PI;
            end else begin
                r.cx = xs;
                r.cy = ys;
                r.cz = '0;
            end
        end
        // radicand and length ratio divider set-up
        if (k == S_RAD) begin
            sm     = {1'b0, s.sqx} + {1'b0, s.sqy};
            r.rad  = {sm, 16'b0};
            r.root = '0;
            r.srem = '0;
            r.lrem = {8'b0, s.maxl[15:8]};
            r.llo  = {s.maxl[7:0], 8'b0};
            r.lq   = '0;
            r.lsat = {8'b0, s.maxl} >= {s.minl, 8'b0};
        end
        // one root bit
        if (k >= S_IT0 && k < S_IT0 + N_ROOT) begin
            sr    = {s.srem[25:0], s.rad[49:48]};
            tr    = {1'b0, s.root, 2'b01};
            r.rad = {s.rad[47:0], 2'b0};
            if (sr >= tr) begin
                r.srem = sr - tr;
                r.root = {s.root[23:0], 1'b1};
            end else begin
                r.srem = sr;
                r.root = {s.root[23:0], 1'b0};
            end
        end
        // one cordic vectoring iteration
        if (k >= S_IT0 && k < S_IT0 + N_CORD) begin
            xs = s.cx >>> (k - S_IT0);
            ys = s.cy >>> (k - S_IT0);
            if (!s.cy[31]) begin
                r.cx = s.cx + ys;
                r.cy = s.cy - xs;
                r.cz = s.cz + f_atan(k - S_IT0);
            end else begin
                r.cx = s.cx - ys;
                r.cy = s.cy + xs;
                r.cz = s.cz - f_atan(k - S_IT0);
            end
        end
        // one length ratio quotient bit
        if (k >= S_IT0 && k < S_IT0 + N_QUO) begin
            dr    = {s.lrem, s.llo[15]};
            r.llo = {s.llo[14:0], 1'b0};
            if (dr >= {1'b0, s.minl}) begin
                r.lrem = 16'(dr - {1'b0, s.minl});
                r.lq   = {s.lq[14:0], 1'b1};
            end else begin
                r.lrem = dr[15:0];
                r.lq   = {s.lq[14:0], 1'b0};
            end
        end
        // deviation of each strip from perpendicular to the roll
        if (k == S_ERR) begin
            roll = s.zr ? 21'sd0 : s.cz;
            ea   = $signed({{3{s.la[14]}}, s.la, 4'b0}) - 22'(roll) - ANG_HALF_PI;
            eb   = $signed({{3{s.ra[14]}}, s.ra, 4'b0}) - 22'(roll) - ANG_HALF_PI;
            r.ea = ea[21] ? 21'(-ea) : ea[20:0];
            r.eb = eb[21] ? 21'(-eb) : eb[20:0];
        end
        // larger deviation, rounded to Q3.12 and saturated
        if (k == S_ERQ) begin
            em    = (s.ea > s.eb) ? s.ea : s.eb;
            rs    = {1'b0, em} + 22'd8;
            r.err = (rs[21:4] > 18'(ERR_MAX)) ? ERR_MAX : rs[18:4];
        end
        // width ratio divider set-up, overflow when root >= maxl * 2^16
        if (k == S_WRI) begin
            r.wrem = {7'b0, s.root[24:16]};
            r.wlo  = s.root[15:0];
            r.wq   = '0;
            r.wsat = {7'b0, s.root[24:16]} >= s.maxl;
        end
        // one width ratio quotient bit
        if (k > S_WRI && k <= S_WRI + N_QUO) begin
            dr    = {s.wrem, s.wlo[15]};
            r.wlo = {s.wlo[14:0], 1'b0};
            if (dr >= {1'b0, s.maxl}) begin
                r.wrem = 16'(dr - {1'b0, s.maxl});
                r.wq   = {s.wq[14:0], 1'b1};
            end else begin
                r.wrem = dr[15:0];
                r.wq   = {s.wq[14:0], 1'b0};
            end
        end
        return r;
    endfunction

    // next value of every stage
    always_comb begin
        n_st[0] = f_load(i_req);
        for (int k = 1; k < DEPTH; k++) begin
            n_st[k] = f_step(r_st[k-1], k);
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_vld};
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_vld  = r_vld[DEPTH-1];
    assign o_item = r_st[DEPTH-1];

    // frozen pipeline keeps its valid bits
    a_hold: assert property (@(posedge i_clk) i_rst_n && !i_en |=> $stable(r_vld))
        else $error("valid bits moved while pipeline held");
    // valid bits advance by exactly one stage
    a_shift: assert property (@(posedge i_clk)
        i_rst_n && i_en |=> r_vld[DEPTH-1:1] == $past(r_vld[DEPTH-2:0]))
        else $error("valid bits did not advance by one stage");
    // longer over shorter is never below one
    a_lr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld |-> (o_item.lsat || o_item.lq >= 16'd256))
        else $error("length ratio below one");
    // zero longer length must saturate the width ratio
    a_wsat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld && o_item.maxl == 16'd0 |-> o_item.wsat)
        else $error("width ratio not saturated on zero length");

endmodule
`default_nettype wire

### rtl/light_strip_pair_geometry.sv
// light_strip_pair_geometry: top level, handshake and result mapping of the pair geometry pipeline
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-----------------------------------------------
//  request  | in        | i_valid / o_stall   | left and right centre, length, angle
//  result   | out       | o_valid / i_stall   | midpoint, width ratio, length ratio, sq error
//
// one request per cycle while o_stall is low; each result leaves the last stage, the depth
// set by the 25-bit root followed by the 16-bit width ratio divider, one bit per stage
// reset is synchronous and active low and clears only the stage valid bits
// a stalled result freezes the whole pipeline; o_stall is high only while a result waits
`default_nettype none
module light_strip_pair_geometry (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [15:0] i_left_center_x,
    input  wire logic [15:0] i_left_center_y,
    input  wire logic [15:0] i_left_length,
    input  wire logic [14:0] i_left_angle,
    input  wire logic [15:0] i_right_center_x,
    input  wire logic [15:0] i_right_center_y,
    input  wire logic [15:0] i_right_length,
    input  wire logic [14:0] i_right_angle,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_mid_x,
    output logic [15:0]      o_mid_y,
    output logic [15:0]      o_width_ratio,
    output logic [15:0]      o_length_ratio,
    output logic [14:0]      o_square_error
);
    import lspg_pkg::*;

    t_req  req;
    t_item res;
    logic  en;
    logic  res_vld;

    // pack the request
    always_comb begin
        req.lx = i_left_center_x;
        req.ly = i_left_center_y;
        req.ll = i_left_length;
        req.la = i_left_angle;
        req.rx = i_right_center_x;
        req.ry = i_right_center_y;
        req.rl = i_right_length;
        req.ra = i_right_angle;
    end

    // pipeline advances unless the finished result is held back
    assign o_stall = res_vld && i_stall;
    assign en      = !o_stall;

    lspg_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_valid),
        .i_req   (req),
        .o_vld   (res_vld),
        .o_item  (res)
    );

    // result fields, ratios saturated
    assign o_valid        = res_vld;
    assign o_mid_x        = res.mid_x;
    assign o_mid_y        = res.mid_y;
    assign o_width_ratio  = res.wsat ? 16'hFFFF : res.wq;
    assign o_length_ratio = res.lsat ? 16'hFFFF : res.lq;
    assign o_square_error = res.err;

endmodule
`default_nettype wire
